// ===== design/rgbcs_pkg.sv =====
package rgbcs_pkg;

    localparam int RED_SHIFT   = 11;
    localparam int GREEN_SHIFT = 5;

    localparam logic [4:0] RED_MAX   = 5'h1F;
    localparam logic [5:0] GREEN_MAX = 6'h3F;
    localparam logic [4:0] BLUE_MAX  = 5'h1F;

    localparam logic [15:0] KEEP_NOT_RED   = 16'h07FF;
    localparam logic [15:0] KEEP_NOT_GREEN = 16'hF81F;
    localparam logic [15:0] KEEP_NOT_BLUE  = 16'hFFE0;

    // channel slots in the per-channel arrays
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int NUM_CH   = 3;

    // channel_mode codes
    localparam logic [1:0] MODE_RED   = 2'd0;
    localparam logic [1:0] MODE_GREEN = 2'd1;
    localparam logic [1:0] MODE_BLUE  = 2'd2;
    localparam logic [1:0] MODE_ALL   = 2'd3;

    // req_type codes
    localparam logic REQ_GATHER = 1'b0;
    localparam logic REQ_APPLY  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_CHANNEL_MODE = 2'd0;
    localparam logic [1:0] REG_RED_GAIN     = 2'd1;
    localparam logic [1:0] REG_GREEN_GAIN   = 2'd2;
    localparam logic [1:0] REG_BLUE_GAIN    = 2'd3;

    localparam int NUM_W = 14;
    localparam int DEN_W = 6;
    localparam int QUO_W = 7;

    typedef struct packed {
        logic [1:0] channel_mode;
        logic [7:0] red_gain;
        logic [7:0] green_gain;
        logic [7:0] blue_gain;
    } cfg_t;

    // one division job: gain*(c-low) over (high-low)
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_t;

    typedef struct packed {
        logic [15:0]         pixel;
        logic [NUM_CH-1:0]   sel;
        div_t [NUM_CH-1:0]   div;
    } entry_t;

endpackage

// ===== design/rgbcs_front.sv =====
module rgbcs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 req_type,
    input  logic [15:0]          pixel_in,
    input  logic                 first,
    input  rgbcs_pkg::cfg_t      cfg,
    input  logic                 full,
    output logic                 busy,
    output logic                 push,
    output rgbcs_pkg::entry_t    push_data
);

    logic [4:0] red_low_reg,   red_low_next,   red_high_reg,   red_high_next;
    logic [5:0] green_low_reg, green_low_next, green_high_reg, green_high_next;
    logic [4:0] blue_low_reg,  blue_low_next,  blue_high_reg,  blue_high_next;

    logic       accept;
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    logic [4:0] r_lo_base, r_hi_base, b_lo_base, b_hi_base;
    logic [5:0] g_lo_base, g_hi_base;

    // empty or flat range, or value at/below low, give a zero quotient (num 0, den 1)
    function automatic rgbcs_pkg::div_t prep(input logic [5:0] c, input logic [5:0] lo,
                                             input logic [5:0] hi, input logic [7:0] gain);
        rgbcs_pkg::div_t d;
        logic [5:0]      diff;
        diff = c - lo;
        if (hi <= lo || c <= lo)
        begin
            d.num = '0;
            d.den = 6'd1;
        end
        else
        begin
            d.num = {6'b0, gain} * {8'b0, diff};
            d.den = hi - lo;
        end
        return d;
    endfunction

    assign busy   = full;
    assign accept = start && !full;
    assign push   = accept && (req_type == rgbcs_pkg::REQ_APPLY);

    assign r = pixel_in[15:11];
    assign g = pixel_in[10:5];
    assign b = pixel_in[4:0];

    always_comb
    begin
        r_lo_base = first ? rgbcs_pkg::RED_MAX   : red_low_reg;
        r_hi_base = first ? 5'd0                 : red_high_reg;
        g_lo_base = first ? rgbcs_pkg::GREEN_MAX : green_low_reg;
        g_hi_base = first ? 6'd0                 : green_high_reg;
        b_lo_base = first ? rgbcs_pkg::BLUE_MAX  : blue_low_reg;
        b_hi_base = first ? 5'd0                 : blue_high_reg;

        red_low_next    = red_low_reg;
        red_high_next   = red_high_reg;
        green_low_next  = green_low_reg;
        green_high_next = green_high_reg;
        blue_low_next   = blue_low_reg;
        blue_high_next  = blue_high_reg;

        if (accept && req_type == rgbcs_pkg::REQ_GATHER)
        begin
            red_low_next    = (r < r_lo_base) ? r : r_lo_base;
            red_high_next   = (r > r_hi_base) ? r : r_hi_base;
            green_low_next  = (g < g_lo_base) ? g : g_lo_base;
            green_high_next = (g > g_hi_base) ? g : g_hi_base;
            blue_low_next   = (b < b_lo_base) ? b : b_lo_base;
            blue_high_next  = (b > b_hi_base) ? b : b_hi_base;
        end
    end

    always_comb
    begin
        push_data.pixel = pixel_in;
        push_data.sel[rgbcs_pkg::CH_RED] =
            cfg.channel_mode inside {rgbcs_pkg::MODE_RED, rgbcs_pkg::MODE_ALL};
        push_data.sel[rgbcs_pkg::CH_GREEN] =
            cfg.channel_mode inside {rgbcs_pkg::MODE_GREEN, rgbcs_pkg::MODE_ALL};
        push_data.sel[rgbcs_pkg::CH_BLUE] =
            cfg.channel_mode inside {rgbcs_pkg::MODE_BLUE, rgbcs_pkg::MODE_ALL};
        push_data.div[rgbcs_pkg::CH_RED] =
            prep({1'b0, r}, {1'b0, red_low_reg}, {1'b0, red_high_reg}, cfg.red_gain);
        push_data.div[rgbcs_pkg::CH_GREEN] =
            prep(g, green_low_reg, green_high_reg, cfg.green_gain);
        push_data.div[rgbcs_pkg::CH_BLUE] =
            prep({1'b0, b}, {1'b0, blue_low_reg}, {1'b0, blue_high_reg}, cfg.blue_gain);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_low_reg    <= rgbcs_pkg::RED_MAX;
            red_high_reg   <= 5'd0;
            green_low_reg  <= rgbcs_pkg::GREEN_MAX;
            green_high_reg <= 6'd0;
            blue_low_reg   <= rgbcs_pkg::BLUE_MAX;
            blue_high_reg  <= 5'd0;
        end
        else
        begin
            red_low_reg    <= red_low_next;
            red_high_reg   <= red_high_next;
            green_low_reg  <= green_low_next;
            green_high_reg <= green_high_next;
            blue_low_reg   <= blue_low_next;
            blue_high_reg  <= blue_high_next;
        end
    end

    // after any gather word the limits of every channel are ordered
    a_limits_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == rgbcs_pkg::REQ_GATHER) |=>
            (red_low_reg <= red_high_reg && green_low_reg <= green_high_reg
             && blue_low_reg <= blue_high_reg))
        else $error("limits out of order after gather word");

endmodule

// ===== design/rgbcs_queue.sv =====
module rgbcs_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rgbcs_pkg::entry_t    push_data,
    input  logic                 pop,
    output rgbcs_pkg::entry_t    pop_data,
    output logic                 full,
    output logic                 empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rgbcs_pkg::entry_t mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg,  count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

endmodule

// ===== design/rgbcs_back.sv =====
module rgbcs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rgbcs_pkg::entry_t    head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 done,
    output logic [15:0]          pixel_out
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } back_state_t;

    localparam int NW = rgbcs_pkg::NUM_W;
    localparam int DW = rgbcs_pkg::DEN_W;
    localparam int QW = rgbcs_pkg::QUO_W;
    localparam int NC = rgbcs_pkg::NUM_CH;

    back_state_t     state_reg, state_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [15:0]     pixel_out_reg, pixel_out_next;

    logic [15:0]     pix_reg,  pix_next;
    logic [NC-1:0]   sel_reg,  sel_next;
    logic [NC-1:0]   ovf_reg,  ovf_next;
    logic [NW-1:0]   rem_reg  [NC];
    logic [NW-1:0]   rem_next [NC];
    logic [DW-1:0]   den_reg  [NC];
    logic [DW-1:0]   den_next [NC];
    logic [QW-1:0]   q_reg    [NC];
    logic [QW-1:0]   q_next   [NC];

    logic [NW-1:0]   trial    [NC];
    logic [4:0]      red_v, blue_v;
    logic [5:0]      green_v;
    logic [15:0]     res;

    assign pop       = (state_reg == ST_IDLE || state_reg == ST_FIN) && !empty;
    assign done      = done_reg;
    assign pixel_out = pixel_out_reg;

    // saturate: overflow flag covers quotients of 128 and more
    always_comb
    begin
        red_v = (ovf_reg[rgbcs_pkg::CH_RED]
                 || q_reg[rgbcs_pkg::CH_RED] > {2'b0, rgbcs_pkg::RED_MAX})
                ? rgbcs_pkg::RED_MAX : q_reg[rgbcs_pkg::CH_RED][4:0];
        green_v = (ovf_reg[rgbcs_pkg::CH_GREEN]
                   || q_reg[rgbcs_pkg::CH_GREEN] > {1'b0, rgbcs_pkg::GREEN_MAX})
                  ? rgbcs_pkg::GREEN_MAX : q_reg[rgbcs_pkg::CH_GREEN][5:0];
        blue_v = (ovf_reg[rgbcs_pkg::CH_BLUE]
                  || q_reg[rgbcs_pkg::CH_BLUE] > {2'b0, rgbcs_pkg::BLUE_MAX})
                 ? rgbcs_pkg::BLUE_MAX : q_reg[rgbcs_pkg::CH_BLUE][4:0];

        res = pix_reg;
        if (sel_reg[rgbcs_pkg::CH_RED])
        begin
            res = {red_v, 11'b0} | (res & rgbcs_pkg::KEEP_NOT_RED);
        end
        if (sel_reg[rgbcs_pkg::CH_GREEN])
        begin
            res = {5'b0, green_v, 5'b0} | (res & rgbcs_pkg::KEEP_NOT_GREEN);
        end
        if (sel_reg[rgbcs_pkg::CH_BLUE])
        begin
            res = {11'b0, blue_v} | (res & rgbcs_pkg::KEEP_NOT_BLUE);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        done_next      = (state_reg == ST_FIN);
        pixel_out_next = pixel_out_reg;
        pix_next       = pix_reg;
        sel_next       = sel_reg;
        ovf_next       = ovf_reg;
        for (int i = 0; i < NC; i++)
        begin
            rem_next[i] = rem_reg[i];
            den_next[i] = den_reg[i];
            q_next[i]   = q_reg[i];
            trial[i]    = {{(NW-DW){1'b0}}, den_reg[i]} << cnt_reg;
        end

        if (state_reg == ST_FIN)
        begin
            pixel_out_next = res;
        end

        case (state_reg)
            ST_IDLE, ST_FIN:
            begin
                if (pop)
                begin
                    pix_next = head.pixel;
                    sel_next = head.sel;
                    for (int i = 0; i < NC; i++)
                    begin
                        rem_next[i] = head.div[i].num;
                        den_next[i] = head.div[i].den;
                        q_next[i]   = '0;
                        ovf_next[i] = head.div[i].num >= {1'b0, head.div[i].den, 7'b0};
                    end
                    cnt_next   = 3'(QW - 1);
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                // one restoring step per cycle, quotient MSB first
                for (int i = 0; i < NC; i++)
                begin
                    if (rem_reg[i] >= trial[i])
                    begin
                        rem_next[i] = rem_reg[i] - trial[i];
                        q_next[i]   = {q_reg[i][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        q_next[i]   = {q_reg[i][QW-2:0], 1'b0};
                    end
                end
                if (cnt_reg == 3'd0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_out_reg <= pixel_out_next;
        pix_reg       <= pix_next;
        sel_reg       <= sel_next;
        ovf_reg       <= ovf_next;
        for (int i = 0; i < NC; i++)
        begin
            rem_reg[i] <= rem_next[i];
            den_reg[i] <= den_next[i];
            q_reg[i]   <= q_next[i];
        end
    end

    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_FIN))
        else $error("done without finished division");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");

    a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == 3'd0) |=> state_reg == ST_FIN)
        else $error("divider did not finish after last step");

endmodule

// ===== design/rgb565_contrast_stretch.sv =====
// Min/max contrast stretch of RGB565 pixels. A gather word (req_type 0) updates the
// channel limits in the cycle it is accepted and gives no result. An apply word
// (req_type 1) is turned into three division jobs and queued (QUEUE_DEPTH entries);
// the back end runs one restoring divider step per cycle for each of the three
// channels in parallel, 7 quotient steps per word followed by an output state in
// which the next queued word is loaded. busy is high while the queue is full. done
// is high for a single cycle with each result word on pixel_out; the receiver
// cannot stall it. Configuration writes are always ready and take effect on words
// accepted afterwards.
module rgb565_contrast_stretch #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [15:0] pixel_in,
    input  logic        first,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        done,
    output logic [15:0] pixel_out
);

    rgbcs_pkg::cfg_t   cfg_reg, cfg_next;
    rgbcs_pkg::entry_t push_data, head;
    logic              push, pop, full, empty;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rgbcs_pkg::REG_CHANNEL_MODE: cfg_next.channel_mode = cfg_data[1:0];
                rgbcs_pkg::REG_RED_GAIN:     cfg_next.red_gain     = cfg_data;
                rgbcs_pkg::REG_GREEN_GAIN:   cfg_next.green_gain   = cfg_data;
                rgbcs_pkg::REG_BLUE_GAIN:    cfg_next.blue_gain    = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_mode <= rgbcs_pkg::MODE_ALL;
            cfg_reg.red_gain     <= 8'd31;
            cfg_reg.green_gain   <= 8'd63;
            cfg_reg.blue_gain    <= 8'd31;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rgbcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .pixel_in  (pixel_in),
        .first     (first),
        .cfg       (cfg_reg),
        .full      (full),
        .busy      (busy),
        .push      (push),
        .push_data (push_data)
    );

    rgbcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (head),
        .full      (full),
        .empty     (empty)
    );

    rgbcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .done      (done),
        .pixel_out (pixel_out)
    );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import rgbcs_pkg::*;

    typedef struct packed {
        logic        req;
        logic [15:0] pixel;
        logic        first;
    } pix_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        req_type = REQ_GATHER;
    logic [15:0] pixel_in = 16'h0000;
    logic        first = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_CHANNEL_MODE;
    logic [7:0]  cfg_data = 8'h00;
    logic        done;
    logic [15:0] pixel_out;

    pix_word_t   pending_words[$];
    logic [15:0] expected_pixels[$];
    cfg_t        shadow_cfg;
    int          ch_low[NUM_CH];
    int          ch_high[NUM_CH];
    int          words_queued = 0;
    int          words_sent = 0;
    int          words_taken = 0;
    int          error_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;

    rgb565_contrast_stretch dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .pixel_in  (pixel_in),
        .first     (first),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .pixel_out (pixel_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic void clear_limits();
        ch_low[CH_RED]    = RED_MAX;
        ch_low[CH_GREEN]  = GREEN_MAX;
        ch_low[CH_BLUE]   = BLUE_MAX;
        ch_high[CH_RED]   = 0;
        ch_high[CH_GREEN] = 0;
        ch_high[CH_BLUE]  = 0;
    endfunction

    function automatic void gather_pixel(logic [15:0] pix, logic restart);
        int c[NUM_CH];
        if (restart)
            clear_limits();
        c[CH_RED]   = (pix >> RED_SHIFT) & RED_MAX;
        c[CH_GREEN] = (pix >> GREEN_SHIFT) & GREEN_MAX;
        c[CH_BLUE]  = pix & BLUE_MAX;
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (c[i] < ch_low[i])
                ch_low[i] = c[i];
            if (c[i] > ch_high[i])
                ch_high[i] = c[i];
        end
    endfunction

    function automatic int stretch_channel(int c, int lo, int hi, int gain, int cap);
        int v;
        // flat or empty range, or at/below the minimum, maps to zero
        if (hi <= lo || c <= lo)
            return 0;
        v = gain * (c - lo) / (hi - lo);
        return (v > cap) ? cap : v;
    endfunction

    function automatic logic [15:0] stretch_pixel(logic [15:0] pix);
        logic [15:0] res;
        int          r, g, b, v;
        r = (pix >> RED_SHIFT) & RED_MAX;
        g = (pix >> GREEN_SHIFT) & GREEN_MAX;
        b = pix & BLUE_MAX;
        res = pix;
        if (shadow_cfg.channel_mode == MODE_RED || shadow_cfg.channel_mode == MODE_ALL)
        begin
            v = stretch_channel(r, ch_low[CH_RED], ch_high[CH_RED],
                                shadow_cfg.red_gain, RED_MAX);
            res = (16'(v) << RED_SHIFT) | (res & KEEP_NOT_RED);
        end
        if (shadow_cfg.channel_mode == MODE_GREEN || shadow_cfg.channel_mode == MODE_ALL)
        begin
            v = stretch_channel(g, ch_low[CH_GREEN], ch_high[CH_GREEN],
                                shadow_cfg.green_gain, GREEN_MAX);
            res = (16'(v) << GREEN_SHIFT) | (res & KEEP_NOT_GREEN);
        end
        if (shadow_cfg.channel_mode == MODE_BLUE || shadow_cfg.channel_mode == MODE_ALL)
        begin
            v = stretch_channel(b, ch_low[CH_BLUE], ch_high[CH_BLUE],
                                shadow_cfg.blue_gain, BLUE_MAX);
            res = 16'(v) | (res & KEEP_NOT_BLUE);
        end
        return res;
    endfunction

    // ---------------- driver ----------------

    always @(negedge clk)
    begin : drive_words
        pix_word_t w;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && words_taken != words_sent)
        begin
            // word still waiting for busy to drop
        end
        else if (gap_left > 0)
        begin
            gap_left = gap_left - 1;
            start <= 1'b0;
        end
        else if (pending_words.size() > 0)
        begin
            w = pending_words.pop_front();
            req_type <= w.req;
            pixel_in <= w.pixel;
            first    <= w.first;
            start    <= 1'b1;
            words_sent = words_sent + 1;
            if (burst_left > 0)
            begin
                burst_left = burst_left - 1;
            end
            else
            begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 8);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin : watch_outputs
        logic [15:0] want;
        if (!rst_n)
        begin
            shadow_cfg.channel_mode = MODE_ALL;
            shadow_cfg.red_gain     = 8'd31;
            shadow_cfg.green_gain   = 8'd63;
            shadow_cfg.blue_gain    = 8'd31;
            clear_limits();
        end
        else
        begin
            if (done !== 1'b0)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel_out: expected none, got %h", pixel_out);
                    error_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (done !== 1'b1 || pixel_out !== want)
                    begin
                        $error("pixel_out: expected %h, got %h", want, pixel_out);
                        error_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CHANNEL_MODE: shadow_cfg.channel_mode = cfg_data[1:0];
                    REG_RED_GAIN:     shadow_cfg.red_gain     = cfg_data;
                    REG_GREEN_GAIN:   shadow_cfg.green_gain   = cfg_data;
                    REG_BLUE_GAIN:    shadow_cfg.blue_gain    = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                words_taken = words_taken + 1;
                if (req_type == REQ_GATHER)
                    gather_pixel(pixel_in, first);
                else
                    expected_pixels.push_back(stretch_pixel(pixel_in));
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic void push_word(logic req, logic [15:0] pix, logic restart);
        pix_word_t w;
        w.req   = req;
        w.pixel = pix;
        w.first = restart;
        pending_words.push_back(w);
        words_queued++;
    endfunction

    function automatic int near_level(int center, int spread, int cap);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > cap)
            v = cap;
        return v;
    endfunction

    // one gather pass over a small image, then an apply pass over it
    function automatic void add_image();
        logic [15:0] img[$];
        logic [15:0] pix;
        int          n, m, rc, gc, bc, rs, gs, bs;
        n  = $urandom_range(1, 12);
        rc = $urandom_range(0, RED_MAX);
        gc = $urandom_range(0, GREEN_MAX);
        bc = $urandom_range(0, BLUE_MAX);
        rs = ($urandom_range(0, 3) == 0) ? RED_MAX : $urandom_range(0, 6);
        gs = ($urandom_range(0, 3) == 0) ? GREEN_MAX : $urandom_range(0, 12);
        bs = ($urandom_range(0, 3) == 0) ? BLUE_MAX : $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
        begin
            pix = {5'(near_level(rc, rs, RED_MAX)), 6'(near_level(gc, gs, GREEN_MAX)),
                   5'(near_level(bc, bs, BLUE_MAX))};
            img.push_back(pix);
            // now and then an image continues the previous limits
            push_word(REQ_GATHER, pix, (i == 0) ? ($urandom_range(0, 7) != 0) : 1'b0);
        end
        m = n + $urandom_range(0, 4);
        for (int i = 0; i < m; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                pix = 16'($urandom);
            else
                pix = img[$urandom_range(0, n - 1)];
            push_word(REQ_APPLY, pix, 1'($urandom_range(0, 1)));
        end
    endfunction

    function automatic void add_random_words(int budget);
        int target;
        target = words_queued + budget;
        while (words_queued < target)
        begin
            if ($urandom_range(0, 99) < 85)
                add_image();
            else
                push_word(1'($urandom_range(0, 1)), 16'($urandom), 1'($urandom_range(0, 1)));
        end
    endfunction

    task automatic drain();
        while (words_taken != words_queued)
            @(negedge clk);
        while (expected_pixels.size() != 0)
            @(negedge clk);
        // gather words leave no result; give the pipeline time to go idle
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    initial
    begin : run_test
        logic [1:0] mode_cycle[4];
        logic [7:0] gain[NUM_CH];
        mode_cycle = '{MODE_RED, MODE_GREEN, MODE_BLUE, MODE_ALL};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no gather yet: empty range gives zero
        push_word(REQ_APPLY, 16'h0000, 1'b0);
        push_word(REQ_APPLY, 16'hFFFF, 1'b0);
        push_word(REQ_APPLY, 16'h1234, 1'b1);
        // flat range, below and above it
        push_word(REQ_GATHER, 16'h8410, 1'b1);
        push_word(REQ_APPLY, 16'h8410, 1'b0);
        push_word(REQ_APPLY, 16'h0000, 1'b0);
        push_word(REQ_APPLY, 16'hFFFF, 1'b0);
        // full range
        push_word(REQ_GATHER, 16'h0000, 1'b1);
        push_word(REQ_GATHER, 16'hFFFF, 1'b0);
        push_word(REQ_APPLY, 16'hFFFF, 1'b0);
        push_word(REQ_APPLY, 16'h0000, 1'b0);
        push_word(REQ_APPLY, 16'h8410, 1'b0);
        push_word(REQ_APPLY, 16'h7BEF, 1'b0);
        push_word(REQ_APPLY, 16'h0821, 1'b0);
        // narrow range: above max saturates, below min is zero
        push_word(REQ_GATHER, 16'h4208, 1'b1);
        push_word(REQ_GATHER, 16'h8410, 1'b0);
        push_word(REQ_APPLY, 16'hFFFF, 1'b0);
        push_word(REQ_APPLY, 16'h0000, 1'b0);
        push_word(REQ_APPLY, 16'h6318, 1'b0);
        push_word(REQ_APPLY, 16'h6318, 1'b1);
        drain();

        for (int phase = 0; phase < 12; phase++)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                case (phase)
                    1: gain[i] = 8'd0;
                    2: gain[i] = 8'd255;
                    3: gain[i] = 8'd1;
                    default: gain[i] = 8'($urandom);
                endcase
            end
            write_reg(REG_CHANNEL_MODE, {6'($urandom), mode_cycle[phase % 4]});
            write_reg(REG_RED_GAIN, gain[CH_RED]);
            write_reg(REG_GREEN_GAIN, gain[CH_GREEN]);
            write_reg(REG_BLUE_GAIN, gain[CH_BLUE]);
            @(negedge clk);
            cfg_valid <= 1'b0;
            add_random_words(130);
            drain();
        end

        if (expected_pixels.size() != 0)
        begin
            $error("pixel_out: %0d words never arrived", expected_pixels.size());
            error_count++;
        end
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
